>>> hw/rtl/pvrvp_pkg.sv
// Package for the planar video register and VRAM port core.
// Holds the shared types, port codes, CRTC write masks and a helper function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvrvp_pkg;

   // Video RAM geometry: four 16 KiB planes, one byte lane per plane
   localparam int VRAM_BYTES     = 65536;
   localparam int PLANE_COUNT    = 4;
   localparam int PLANE_BYTES    = VRAM_BYTES / PLANE_COUNT;
   localparam int ROW_AW         = $clog2(PLANE_BYTES);
   localparam int PLANE_SEL_W    = $clog2(PLANE_COUNT);

   // CRTC register file
   localparam int CRTC_REG_COUNT = 32;
   localparam int CRTC_IX_W      = $clog2(CRTC_REG_COUNT);

   // Mode bits that select planar mode when both set
   localparam logic [7:0] PLANAR_BITS = 8'h12;

   // First and last non-timing CRTC registers (cursor and start address)
   localparam logic [CRTC_IX_W-1:0] CRTC_NT_FIRST = 5'd14;
   localparam logic [CRTC_IX_W-1:0] CRTC_NT_LAST  = 5'd16;

   // Values forced on entering planar mode
   localparam logic [7:0] PLANE_MASK_ALL = 8'h0f;

   // Read data of an unmapped io port
   localparam logic [7:0] RDATA_UNMAPPED = 8'hff;

   // Bus function codes
   typedef enum logic [1:0] {
      FUNC_IO_WR  = 2'd0,
      FUNC_IO_RD  = 2'd1,
      FUNC_MEM_WR = 2'd2,
      FUNC_MEM_RD = 2'd3
   } func_type;

   // Io port offsets
   typedef enum logic [3:0] {
      PORT_0          = 4'h0,
      PORT_1          = 4'h1,
      PORT_2          = 4'h2,
      PORT_3          = 4'h3,
      PORT_CRTC_INDEX = 4'h4,
      PORT_CRTC_DATA  = 4'h5,
      PORT_6          = 4'h6,
      PORT_7          = 4'h7,
      PORT_MODE       = 4'h8,
      PORT_COLOUR     = 4'h9,
      PORT_STATUS     = 4'ha,
      PORT_B          = 4'hb,
      PORT_C          = 4'hc,
      PORT_PLANE_MASK = 4'hd,
      PORT_PLANE_SEL  = 4'he,
      PORT_BORDER     = 4'hf
   } port_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;    // capture the request, start the VRAM row read
      logic commit;    // update state, load the result register
      logic clear_we;  // write one zero row of the clearing pass
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last; // clearing pass is on its last row
   } status_type;

   // Per-register CRTC write masks
   localparam logic [7:0] CRTC_WMASK [CRTC_REG_COUNT] = '{
      8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
      8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff,
      8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic logic is_planar(input logic [7:0] mode);
      return (mode & PLANAR_BITS) == PLANAR_BITS;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/planar_video_register_and_vram_port_core.sv
// Flow: an accepted item's request and VRAM row read are registered; the item
// then waits in execute until the result register is free, and its result is
// registered on commit. No new request is taken until the item is committed.
// Reset: synchronous, active high; afterwards a clearing pass zeroes the VRAM
// one row of four planes per cycle, with req_stall held high.
// Top level of the planar video register and VRAM port; uses pvrvp_pkg,
// pvrvp_ctrl and pvrvp_dpath.
`timescale 1ns / 1ps
`default_nettype none

module planar_video_register_and_vram_port_core
   import pvrvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [14:0] req_address,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [7:0]  req_timing_status,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_rdata,
   output logic             rsp_timing_changed
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   pvrvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, VRAM and result
   pvrvp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_address        (req_address),
      .req_wdata          (req_wdata),
      .req_timing_status  (req_timing_status),
      .rsp_rdata          (rsp_rdata),
      .rsp_timing_changed (rsp_timing_changed)
   );

endmodule

`default_nettype wire

>>> hw/rtl/pvrvp_ctrl.sv
// Controller of the planar video register and VRAM port core.
// Sequences the VRAM clearing pass and the accept-execute item flow; uses pvrvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvrvp_ctrl
   import pvrvp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new item
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      cmd.clear_we = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_we = 1'b1;
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_EXEC: cmd.commit = out_free;
         default: ;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted item is executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_EXEC)
      else $error("accepted item did not reach execute");

   // A committed item is always presented
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed item not presented");

   // Clearing pass ends only on its last row
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_CLEAR && state_ff == ST_IDLE) |-> $past(status.clear_last))
      else $error("clearing pass left early");

endmodule

`default_nettype wire

>>> hw/rtl/pvrvp_dpath.sv
// Datapath of the planar video register and VRAM port core.
// Holds the adapter registers, CRTC file, four-lane VRAM and result register;
// uses pvrvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvrvp_dpath
   import pvrvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [1:0]  req_func,
   input  wire logic [14:0] req_address,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [7:0]  req_timing_status,
   output logic [7:0]       rsp_rdata,
   output logic             rsp_timing_changed
);

   // Captured request
   func_type    func_ff;
   logic [14:0] addr_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  tstat_ff;

   // Adapter registers
   logic [7:0]           crtc_regs_ff [CRTC_REG_COUNT];
   logic [CRTC_IX_W-1:0] crtc_index_ff, crtc_index_in;
   logic [7:0]           mode_reg_ff, mode_reg_in;
   logic [7:0]           colour_reg_ff, colour_reg_in;
   logic [7:0]           plane_write_mask_ff, plane_write_mask_in;
   logic [PLANE_SEL_W-1:0] plane_read_sel_ff, plane_read_sel_in;
   logic [7:0]           border_reg_ff, border_reg_in;

   // Clearing pass row counter
   logic [ROW_AW-1:0] clr_row_ff, clr_row_in;

   // VRAM: one row holds the same offset of all four planes
   logic [8*PLANE_COUNT-1:0] vram_mem [PLANE_BYTES];
   logic [8*PLANE_COUNT-1:0] rd_row_ff;
   logic                     mem_we;
   logic [ROW_AW-1:0]        mem_waddr;
   logic [PLANE_COUNT-1:0]   mem_be;
   logic [8*PLANE_COUNT-1:0] mem_wdata;

   // Result register
   logic [7:0] rdata_ff, rdata_in;
   logic       changed_ff, changed_in;

   port_type               port;
   logic                   planar;
   logic [7:0]             crtc_cur;
   logic                   crtc_timing_reg;
   logic [PLANE_SEL_W-1:0] rd_lane;

   assign port            = port_type'(addr_ff[3:0]);
   assign planar          = is_planar(mode_reg_ff);
   assign crtc_cur        = crtc_regs_ff[crtc_index_ff];
   assign crtc_timing_reg = (crtc_index_ff < CRTC_NT_FIRST) || (crtc_index_ff > CRTC_NT_LAST);
   assign rd_lane         = planar ? plane_read_sel_ff : '0;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= func_type'(req_func);
         addr_ff  <= req_address;
         wdata_ff <= req_wdata;
         tstat_ff <= req_timing_status;
      end
   end

   // Register updates on io write
   always_comb begin
      crtc_index_in       = crtc_index_ff;
      mode_reg_in         = mode_reg_ff;
      colour_reg_in       = colour_reg_ff;
      plane_write_mask_in = plane_write_mask_ff;
      plane_read_sel_in   = plane_read_sel_ff;
      border_reg_in       = border_reg_ff;
      if (cmd.commit && func_ff == FUNC_IO_WR) begin
         unique case (port)
            PORT_CRTC_INDEX: crtc_index_in = wdata_ff[CRTC_IX_W-1:0];
            PORT_MODE: begin
               mode_reg_in = wdata_ff;
               if (is_planar(wdata_ff) && !planar) begin
                  plane_write_mask_in = PLANE_MASK_ALL;
                  plane_read_sel_in   = '0;
               end
            end
            PORT_COLOUR:     colour_reg_in       = wdata_ff;
            PORT_PLANE_MASK: plane_write_mask_in = wdata_ff;
            PORT_PLANE_SEL:  plane_read_sel_in   = wdata_ff[PLANE_SEL_W-1:0];
            PORT_BORDER:     border_reg_in       = wdata_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crtc_index_ff       <= '0;
         mode_reg_ff         <= PLANAR_BITS;
         colour_reg_ff       <= 8'd7;
         plane_write_mask_ff <= '0;
         plane_read_sel_ff   <= '0;
         border_reg_ff       <= '0;
      end else begin
         crtc_index_ff       <= crtc_index_in;
         mode_reg_ff         <= mode_reg_in;
         colour_reg_ff       <= colour_reg_in;
         plane_write_mask_ff <= plane_write_mask_in;
         plane_read_sel_ff   <= plane_read_sel_in;
         border_reg_ff       <= border_reg_in;
      end
   end

   // CRTC register file, stored masked
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CRTC_REG_COUNT; i++) crtc_regs_ff[i] <= '0;
      end else if (cmd.commit && func_ff == FUNC_IO_WR && port == PORT_CRTC_DATA) begin
         crtc_regs_ff[crtc_index_ff] <= wdata_ff & CRTC_WMASK[crtc_index_ff];
      end
   end

   // Clearing pass counter
   assign clr_row_in        = clr_row_ff + 1'b1;
   assign status.clear_last = (clr_row_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_row_ff <= clr_row_in;
      end
   end

   // VRAM write port: zero rows while clearing, else the enabled planes (plane 0 outside planar mode)
   always_comb begin
      mem_we    = cmd.clear_we || (cmd.commit && func_ff == FUNC_MEM_WR);
      mem_waddr = addr_ff[ROW_AW-1:0];
      mem_be    = planar ? plane_write_mask_ff[PLANE_COUNT-1:0] : PLANE_COUNT'(1);
      mem_wdata = {PLANE_COUNT{wdata_ff}};
      if (cmd.clear_we) begin
         mem_waddr = clr_row_ff;
         mem_be    = '1;
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int l = 0; l < PLANE_COUNT; l++) begin
            if (mem_be[l]) vram_mem[mem_waddr][8*l +: 8] <= mem_wdata[8*l +: 8];
         end
      end
   end

   // VRAM read port: row read at accept, lane picked in execute
   always_ff @(posedge clock) begin
      if (cmd.accept) rd_row_ff <= vram_mem[req_address[ROW_AW-1:0]];
   end

   // Result of the item in execute
   always_comb begin
      rdata_in   = '0;
      changed_in = 1'b0;
      case (func_ff)
         FUNC_IO_WR: begin
            changed_in = (port == PORT_CRTC_DATA) && (crtc_cur != wdata_ff) && crtc_timing_reg;
         end
         FUNC_IO_RD: begin
            case (port)
               PORT_CRTC_INDEX: rdata_in = 8'(crtc_index_ff);
               PORT_CRTC_DATA:  rdata_in = crtc_cur;
               PORT_STATUS:     rdata_in = tstat_ff;
               default:         rdata_in = RDATA_UNMAPPED;
            endcase
         end
         FUNC_MEM_WR: ;
         FUNC_MEM_RD: rdata_in = rd_row_ff[8*rd_lane +: 8];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rdata_ff   <= rdata_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_rdata          = rdata_ff;
   assign rsp_timing_changed = changed_ff;

   // Colour and border registers are held for the display side only;
   // address bit 14 is the window mirror
   logic unused_regs;
   assign unused_regs = ^{colour_reg_ff, border_reg_ff, plane_write_mask_ff[7:PLANE_COUNT],
                          addr_ff[14]};

   // Entering planar mode resets the plane controls
   a_planar_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == FUNC_IO_WR && port == PORT_MODE &&
       is_planar(wdata_ff) && !planar)
      |=> (plane_write_mask_ff == PLANE_MASK_ALL && plane_read_sel_ff == '0))
      else $error("plane controls not reset on planar entry");

   // Timing change flag only follows a CRTC data write
   a_changed_src: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (!changed_ff ||
                      ($past(func_ff) == FUNC_IO_WR && $past(port) == PORT_CRTC_DATA)))
      else $error("timing change flag on a non-CRTC item");

   // No item is taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> !cmd.accept && !cmd.commit)
      else $error("item handled during clearing pass");

endmodule

`default_nettype wire

>>> dv/pvrvp_bus_checker.sv
// Checker for the planar video register and VRAM port: watches both channels,
// predicts each bus reply and compares it with what the block returns.
// Depends on pvrvp_pkg for the bus function and io port codes.
`timescale 1ns / 1ps

module pvrvp_bus_checker
   import pvrvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [14:0] req_address,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [7:0]  req_timing_status,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_rdata,
   input  wire logic        rsp_timing_changed,
   output int               fail_count,
   output int               outstanding
);

   localparam int         VRAM_SIZE   = 65536;
   localparam logic [7:0] MODE_PLANAR = 8'h12;
   // cursor and start address registers do not count as timing registers
   localparam logic [4:0] NON_TIMING_LO = 5'd14;
   localparam logic [4:0] NON_TIMING_HI = 5'd16;

   // bits of each CRTC register that are kept on a write
   localparam logic [7:0] CRTC_KEEP [32] = '{
      8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
      8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff,
      8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [7:0] rdata;
      logic       timing_changed;
   } bus_reply_type;

   // shadow copy of the adapter state
   logic [7:0] vram [VRAM_SIZE];
   logic [7:0] crtc_file [32];
   logic [4:0] crtc_ix;
   logic [7:0] mode_q;
   logic [7:0] plane_wmask_q;
   logic [1:0] plane_rsel_q;

   bus_reply_type bus_reply_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Apply one bus access to the shadow state and work out its reply
   task automatic decode_bus_access(input func_type f, input logic [14:0] addr,
                                    input logic [7:0] wd, input logic [7:0] ts,
                                    output bus_reply_type reply);
      port_type    port;
      logic [13:0] row;
      logic [4:0]  ix;
      logic        planar;
      begin
         port   = port_type'(addr[3:0]);
         row    = addr[13:0];   // bit 14 mirrors the window
         ix     = crtc_ix;
         planar = (mode_q & MODE_PLANAR) == MODE_PLANAR;
         reply  = '0;
         case (f)
            FUNC_IO_WR: begin
               case (port)
                  PORT_CRTC_INDEX: crtc_ix = wd[4:0];
                  PORT_CRTC_DATA: begin
                     // judged on the unmasked byte
                     if (crtc_file[ix] != wd && (ix < NON_TIMING_LO || ix > NON_TIMING_HI))
                        reply.timing_changed = 1'b1;
                     crtc_file[ix] = wd & CRTC_KEEP[ix];
                  end
                  PORT_MODE: begin
                     if ((wd & MODE_PLANAR) == MODE_PLANAR && !planar) begin
                        plane_wmask_q = 8'h0f;
                        plane_rsel_q  = 2'd0;
                     end
                     mode_q = wd;
                  end
                  PORT_PLANE_MASK: plane_wmask_q = wd;
                  PORT_PLANE_SEL:  plane_rsel_q  = wd[1:0];
                  // colour and border have no read-back path
                  default: ;
               endcase
            end
            FUNC_IO_RD: begin
               case (port)
                  PORT_CRTC_INDEX: reply.rdata = {3'b000, crtc_ix};
                  PORT_CRTC_DATA:  reply.rdata = crtc_file[ix];
                  PORT_STATUS:     reply.rdata = ts;
                  default:         reply.rdata = 8'hff;
               endcase
            end
            FUNC_MEM_WR: begin
               if (planar) begin
                  // mask bits 4..7 are stored but select nothing
                  for (int p = 0; p < 4; p++)
                     if (plane_wmask_q[p])
                        vram[{p[1:0], row}] = wd;
               end else begin
                  vram[{2'b00, row}] = wd;
               end
            end
            default: begin
               if (planar)
                  reply.rdata = vram[{plane_rsel_q, row}];
               else
                  reply.rdata = vram[{2'b00, row}];
            end
         endcase
      end
   endtask

   // Compare replies in order, then log each accepted access
   always @(posedge clock) begin : watch
      bus_reply_type want;
      bus_reply_type got;
      logic          bad;
      bad = 1'b0;
      if (reset) begin
         for (int a = 0; a < VRAM_SIZE; a++)
            vram[a] = 8'h00;
         for (int r = 0; r < 32; r++)
            crtc_file[r] = 8'h00;
         crtc_ix       = 5'd0;
         mode_q        = MODE_PLANAR;
         plane_wmask_q = 8'h00;
         plane_rsel_q  = 2'd0;
         bus_reply_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.rdata          = rsp_rdata;
            got.timing_changed = rsp_timing_changed;
            if (bus_reply_q.size() == 0) begin
               $display("%0t: reply with nothing pending, rdata %02h timing_changed %0b",
                        $time, got.rdata, got.timing_changed);
               bad = 1'b1;
            end else begin
               want = bus_reply_q.pop_front();
               if (got.rdata !== want.rdata) begin
                  $display("%0t: rdata mismatch, expected %02h actual %02h",
                           $time, want.rdata, got.rdata);
                  bad = 1'b1;
               end
               if (got.timing_changed !== want.timing_changed) begin
                  $display("%0t: timing_changed mismatch, expected %0b actual %0b",
                           $time, want.timing_changed, got.timing_changed);
                  bad = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_bus_access(func_type'(req_func), req_address, req_wdata,
                              req_timing_status, want);
            bus_reply_q.push_back(want);
         end
      end
      if (bad)
         fail_count <= fail_count + 1;
      outstanding <= bus_reply_q.size();
   end

endmodule

>>> dv/tb_top.sv
// Top of the testbench for planar_video_register_and_vram_port_core: drives
// bus accesses and reply stalls, gives the verdict.
// Depends on pvrvp_pkg, the core and pvrvp_bus_checker.
`timescale 1ns / 1ps

module tb_top;
   import pvrvp_pkg::*;

   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [14:0] req_address;
   logic [7:0]  req_wdata;
   logic [7:0]  req_timing_status;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_rdata;
   logic        rsp_timing_changed;

   int   fail_count;
   int   outstanding;
   logic idling_on = 1'b1;
   logic hold_req  = 1'b0;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   planar_video_register_and_vram_port_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_address        (req_address),
      .req_wdata          (req_wdata),
      .req_timing_status  (req_timing_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rdata          (rsp_rdata),
      .rsp_timing_changed (rsp_timing_changed)
   );

   pvrvp_bus_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_address        (req_address),
      .req_wdata          (req_wdata),
      .req_timing_status  (req_timing_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rdata          (rsp_rdata),
      .rsp_timing_changed (rsp_timing_changed),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // Offer one item, with an occasional gap first, and wait for it to be taken
   task automatic send_item(input func_type f, input logic [14:0] addr,
                            input logic [7:0] wd, input logic [7:0] ts);
      int gap;
      begin
         if (idling_on && $urandom_range(99) < 6) begin
            gap = $urandom_range(4, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid         <= 1'b1;
         req_func          <= f;
         req_address       <= addr;
         req_wdata         <= wd;
         req_timing_status <= ts;
         do @(posedge clock); while (req_stall);
      end
   endtask

   task automatic io_wr(input port_type port, input logic [7:0] wd);
      send_item(FUNC_IO_WR, {11'h000, port}, wd, 8'($urandom_range(255)));
   endtask

   task automatic io_rd(input port_type port, input logic [7:0] ts);
      send_item(FUNC_IO_RD, {11'h000, port}, 8'($urandom_range(255)), ts);
   endtask

   task automatic mem_wr(input logic [14:0] addr, input logic [7:0] wd);
      send_item(FUNC_MEM_WR, addr, wd, 8'($urandom_range(255)));
   endtask

   task automatic mem_rd(input logic [14:0] addr);
      send_item(FUNC_MEM_RD, addr, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   // Wait until every reply that was predicted has come back
   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Reply side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(99) < 6);
         end
      end
   end

   // Stimulus
   initial begin
      logic [14:0] addr;
      logic [7:0]  wd;
      logic [7:0]  ts;
      logic [3:0]  port;
      int          pick;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_IO_WR;
      req_address       = '0;
      req_wdata         = '0;
      req_timing_status = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, unmapped ports, mirror, planar entry, CRTC masks
      io_rd(PORT_CRTC_INDEX, 8'h00);
      io_rd(PORT_STATUS, 8'ha5);
      send_item(FUNC_IO_RD, 15'h7ff0, 8'h00, 8'h00);
      mem_wr(15'h7fff, 8'haa);              // planar with no plane enabled
      io_wr(PORT_MODE, 8'h00);
      mem_wr(15'h3fff, 8'h55);
      mem_rd(15'h7fff);                     // mirrored at 16 KiB
      io_wr(PORT_MODE, 8'h12);              // entering planar enables all planes
      mem_wr(15'h0001, 8'ha5);
      io_wr(PORT_PLANE_SEL, 8'hff);
      mem_rd(15'h4001);
      io_wr(PORT_PLANE_MASK, 8'hf2);        // upper mask bits do nothing
      mem_wr(15'h0000, 8'h3c);
      io_wr(PORT_PLANE_SEL, 8'h01);
      mem_rd(15'h0000);
      io_wr(PORT_CRTC_INDEX, 8'hff);
      io_wr(PORT_CRTC_DATA, 8'h80);         // fully masked register still flags
      io_rd(PORT_CRTC_DATA, 8'h00);
      io_wr(PORT_CRTC_INDEX, 8'd14);
      io_wr(PORT_CRTC_DATA, 8'hff);         // cursor register: no flag
      io_wr(PORT_CRTC_INDEX, 8'd8);
      io_wr(PORT_CRTC_DATA, 8'hff);
      io_wr(PORT_CRTC_DATA, 8'hff);         // same byte, flags on masked bits
      io_rd(PORT_CRTC_DATA, 8'hff);
      send_item(FUNC_IO_WR, 15'h7ff0, 8'hff, 8'hff);

      // random mix, mostly on a small set of rows so reads find written data
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_req = 1'b1;
         if (n == 600) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         idling_on = !(n >= 400 && n < 550);
         wd   = 8'($urandom_range(255));
         ts   = 8'($urandom_range(255));
         addr = 15'($urandom_range(32767));
         pick = $urandom_range(99);
         if (pick < 30) begin
            case ($urandom_range(9))
               0:       port = PORT_CRTC_INDEX;
               1, 2:    port = PORT_CRTC_DATA;
               3: begin
                  port = PORT_MODE;
                  case ($urandom_range(4))
                     0:       wd = 8'h12;
                     1:       wd = 8'h00;
                     2:       wd = 8'h10;
                     3:       wd = 8'h02;
                     default: ;
                  endcase
               end
               4:       port = PORT_PLANE_MASK;
               5:       port = PORT_PLANE_SEL;
               6:       port = PORT_COLOUR;
               7:       port = PORT_BORDER;
               default: port = 4'($urandom_range(15));
            endcase
            addr[3:0] = port;
            send_item(FUNC_IO_WR, addr, wd, ts);
         end else if (pick < 50) begin
            case ($urandom_range(4))
               0, 1:    port = PORT_CRTC_DATA;
               2:       port = PORT_CRTC_INDEX;
               3:       port = PORT_STATUS;
               default: port = 4'($urandom_range(15));
            endcase
            addr[3:0] = port;
            send_item(FUNC_IO_RD, addr, wd, ts);
         end else begin
            if ($urandom_range(9) < 7)
               addr[13:4] = $urandom_range(1) ? 10'h3ff : 10'h000;
            if (pick < 75)
               send_item(FUNC_MEM_WR, addr, wd, ts);
            else
               send_item(FUNC_MEM_RD, addr, wd, ts);
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
